[hdl/modbus_register_slave_defines.svh]
`ifndef MODBUS_REGISTER_SLAVE_DEFINES_SVH
`define MODBUS_REGISTER_SLAVE_DEFINES_SVH

// same-cycle implication check
`define MRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication check
`define MRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mrs_pkg.sv]
package mrs_pkg;

    localparam int READ_REG_COUNT_DEF    = 9;
    localparam int VALVE_REG_ADDRESS_DEF = 9;
    localparam int FRAME_LEN             = 8;

    localparam logic [3:0]  COUNT_FULL     = 4'd8;
    localparam logic [3:0]  COUNT_SAT      = 4'd9;
    localparam logic [7:0]  FN_READ        = 8'h03;
    localparam logic [7:0]  FN_WRITE       = 8'h06;
    localparam logic [7:0]  DEV_ADDR_RESET = 8'h01;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_TELEM = 2'd1;
    localparam logic [1:0] ACT_TAKE  = 2'd2;

    localparam logic [1:0] VALVE_NONE  = 2'd0;
    localparam logic [1:0] VALVE_OPEN  = 2'd1;
    localparam logic [1:0] VALVE_CLOSE = 2'd2;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [2:0] SRC_FRAME  = 3'd0;
    localparam logic [2:0] SRC_BCNT   = 3'd1;
    localparam logic [2:0] SRC_WHI    = 3'd2;
    localparam logic [2:0] SRC_WLO    = 3'd3;
    localparam logic [2:0] SRC_CRCL   = 3'd4;
    localparam logic [2:0] SRC_CRCH   = 3'd5;
    localparam logic [2:0] SRC_REPORT = 3'd6;

    typedef struct packed {
        logic       take_byte;
        logic       mem_wr;
        logic       frame_clear;
        logic       tx_init;
        logic       word_load;
        logic       word_next;
        logic       valve_latch;
        logic       valve_take;
        logic       emit;
        logic [2:0] sel;
        logic [2:0] fidx;
        logic       last;
        logic       crc_upd;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic read_ok;
        logic write_ok;
        logic last_word;
    } t_status;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hdl/mrs_req_if.sv]
interface mrs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  request_byte;
    logic        frame_end;
    logic [3:0]  telemetry_index;
    logic [15:0] telemetry_value;

    modport source (
        output valid, action, request_byte, frame_end, telemetry_index, telemetry_value,
        input  ready
    );
    modport sink (
        input  valid, action, request_byte, frame_end, telemetry_index, telemetry_value,
        output ready
    );
endinterface

[hdl/mrs_rsp_if.sv]
interface mrs_rsp_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] response_byte;
    logic       response_last;
    logic [1:0] valve_command;

    modport source (
        output valid, result_kind, response_byte, response_last, valve_command,
        input  ready
    );
    modport sink (
        input  valid, result_kind, response_byte, response_last, valve_command,
        output ready
    );
endinterface

[hdl/mrs_datapath.sv]
module mrs_datapath #(
    parameter int READ_REG_COUNT    = mrs_pkg::READ_REG_COUNT_DEF,
    parameter int VALVE_REG_ADDRESS = mrs_pkg::VALVE_REG_ADDRESS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    input  logic [7:0]       i_request_byte,
    input  logic [3:0]       i_telemetry_index,
    input  logic [15:0]      i_telemetry_value,
    input  mrs_pkg::t_cmd    i_cmd,
    output mrs_pkg::t_status o_status,
    mrs_rsp_if.source        o_rsp
);
    import mrs_pkg::*;

    localparam int AW = (READ_REG_COUNT > 1) ? $clog2(READ_REG_COUNT) : 1;
    localparam int CW = $clog2(READ_REG_COUNT + 1);
    localparam logic [16:0]   RRC_SPAN   = 17'(READ_REG_COUNT);
    localparam logic [AW+3:0] RRC_IDX    = (AW + 4)'(READ_REG_COUNT);
    localparam logic [15:0]   VALVE_ADDR = 16'(VALVE_REG_ADDRESS);

    logic [7:0]  r_dev_addr;
    logic [7:0]  r_frame [FRAME_LEN];
    logic [3:0]  r_count;
    logic [15:0] r_crc;
    logic [15:0] r_tx_crc;
    logic [1:0]  r_pending;

    logic [15:0]               r_mem [READ_REG_COUNT];
    logic [READ_REG_COUNT-1:0] r_mem_vld;
    logic [15:0]               r_rd_data;
    logic                      r_rd_vld;
    logic [AW-1:0]             r_word_addr;
    logic [CW-1:0]             r_words_left;

    logic       r_out_valid;
    logic       r_out_kind;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic [1:0] r_out_valve;

    logic [15:0]   w_addr16;
    logic [15:0]   w_qty;
    logic [16:0]   w_span;
    logic          w_base_ok;
    logic [15:0]   w_word;
    logic [AW+3:0] w_tel_wide;
    logic [AW-1:0] w_tel_addr;
    logic          w_tel_ok;
    logic          w_slot_free;
    logic [7:0]    n_byte;

    assign w_addr16    = {r_frame[2], r_frame[3]};
    assign w_qty       = {r_frame[4], r_frame[5]};
    assign w_span      = {1'b0, w_addr16} + {1'b0, w_qty};
    assign w_base_ok   = (r_count == COUNT_FULL) && (r_frame[0] == r_dev_addr)
                         && (r_crc == 16'h0000);
    assign w_word      = r_rd_vld ? r_rd_data : 16'h0000;
    assign w_tel_wide  = {{AW{1'b0}}, i_telemetry_index};
    assign w_tel_addr  = w_tel_wide[AW-1:0];
    assign w_tel_ok    = w_tel_wide < RRC_IDX;
    assign w_slot_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        o_status.slot_free = w_slot_free;
        o_status.read_ok   = w_base_ok && (r_frame[1] == FN_READ) && (w_qty != 16'h0000)
                             && (w_span <= RRC_SPAN);
        o_status.write_ok  = w_base_ok && (r_frame[1] == FN_WRITE) && (w_addr16 == VALVE_ADDR);
        o_status.last_word = r_words_left == CW'(1);
    end

    always_comb begin
        case (i_cmd.sel)
            SRC_FRAME:  n_byte = r_frame[i_cmd.fidx];
            SRC_BCNT:   n_byte = {w_qty[6:0], 1'b0};
            SRC_WHI:    n_byte = w_word[15:8];
            SRC_WLO:    n_byte = w_word[7:0];
            SRC_CRCL:   n_byte = r_tx_crc[7:0];
            SRC_CRCH:   n_byte = r_tx_crc[15:8];
            default:    n_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RESET;
        end else if (i_cfg_wr_en) begin
            r_dev_addr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte && (r_count < COUNT_FULL)) begin
            r_frame[r_count[2:0]] <= i_request_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 4'd0;
            r_crc   <= CRC_INIT;
        end else if (i_cmd.frame_clear) begin
            r_count <= 4'd0;
            r_crc   <= CRC_INIT;
        end else if (i_cmd.take_byte) begin
            if (r_count < COUNT_FULL) begin
                r_count <= r_count + 4'd1;
                r_crc   <= crc_feed(r_crc, i_request_byte);
            end else begin
                r_count <= COUNT_SAT;
            end
        end
    end

    // telemetry store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && w_tel_ok) begin
            r_mem[w_tel_addr] <= i_telemetry_value;
        end
        r_rd_data <= r_mem[r_word_addr];
        r_rd_vld  <= r_mem_vld[r_word_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (i_cmd.mem_wr && w_tel_ok) begin
            r_mem_vld[w_tel_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.word_load) begin
            r_word_addr  <= w_addr16[AW-1:0];
            r_words_left <= w_qty[CW-1:0];
        end else if (i_cmd.word_next) begin
            r_word_addr  <= r_word_addr + AW'(1);
            r_words_left <= r_words_left - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tx_init) begin
            r_tx_crc <= CRC_INIT;
        end else if (i_cmd.emit && i_cmd.crc_upd) begin
            r_tx_crc <= crc_feed(r_tx_crc, n_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= VALVE_NONE;
        end else if (i_cmd.valve_latch) begin
            r_pending <= (w_qty == 16'h0000) ? VALVE_OPEN : VALVE_CLOSE;
        end else if (i_cmd.valve_take) begin
            r_pending <= VALVE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind  <= (i_cmd.sel == SRC_REPORT) ? KIND_REPORT : KIND_BYTE;
            r_out_byte  <= n_byte;
            r_out_last  <= i_cmd.last;
            r_out_valve <= (i_cmd.sel == SRC_REPORT) ? r_pending : VALVE_NONE;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.result_kind   = r_out_kind;
    assign o_rsp.response_byte = r_out_byte;
    assign o_rsp.response_last = r_out_last;
    assign o_rsp.valve_command = r_out_valve;

endmodule

[hdl/mrs_ctrl.sv]
`include "modbus_register_slave_defines.svh"

module mrs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mrs_req_if.sink          i_req,
    input  mrs_pkg::t_status i_status,
    output mrs_pkg::t_cmd    o_cmd
);
    import mrs_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_HEAD   = 4'd2;
    localparam logic [3:0] S_FETCH  = 4'd3;
    localparam logic [3:0] S_WHI    = 4'd4;
    localparam logic [3:0] S_WLO    = 4'd5;
    localparam logic [3:0] S_CRCL   = 4'd6;
    localparam logic [3:0] S_CRCH   = 4'd7;
    localparam logic [3:0] S_REPORT = 4'd8;

    localparam logic [2:0] READ_HEAD_LAST  = 3'd2;
    localparam logic [2:0] WRITE_HEAD_LAST = 3'd5;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [2:0] r_step;
    logic [2:0] n_step;
    logic       r_is_read;
    logic       n_is_read;
    logic       w_accept;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_step    = r_step;
        n_is_read = r_is_read;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.action)
                        ACT_BYTE: begin
                            o_cmd.take_byte = 1'b1;
                            if (i_req.frame_end) begin
                                n_state = S_CHECK;
                            end
                        end
                        ACT_TELEM: begin
                            o_cmd.mem_wr = 1'b1;
                        end
                        ACT_TAKE: begin
                            n_state = S_REPORT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CHECK: begin
                o_cmd.frame_clear = 1'b1;
                o_cmd.tx_init     = 1'b1;
                n_step            = 3'd0;
                if (i_status.read_ok) begin
                    o_cmd.word_load = 1'b1;
                    n_is_read       = 1'b1;
                    n_state         = S_HEAD;
                end else if (i_status.write_ok) begin
                    o_cmd.valve_latch = 1'b1;
                    n_is_read         = 1'b0;
                    n_state           = S_HEAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_HEAD: begin
                o_cmd.sel     = (r_is_read && (r_step == READ_HEAD_LAST)) ? SRC_BCNT : SRC_FRAME;
                o_cmd.fidx    = r_step;
                o_cmd.crc_upd = 1'b1;
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_step     = r_step + 3'd1;
                    if (r_is_read && (r_step == READ_HEAD_LAST)) begin
                        n_state = S_FETCH;
                    end else if (!r_is_read && (r_step == WRITE_HEAD_LAST)) begin
                        n_state = S_CRCL;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_WHI;
            end
            S_WHI: begin
                o_cmd.sel     = SRC_WHI;
                o_cmd.crc_upd = 1'b1;
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_WLO;
                end
            end
            S_WLO: begin
                o_cmd.sel     = SRC_WLO;
                o_cmd.crc_upd = 1'b1;
                if (i_status.slot_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.word_next = 1'b1;
                    n_state         = i_status.last_word ? S_CRCL : S_FETCH;
                end
            end
            S_CRCL: begin
                o_cmd.sel = SRC_CRCL;
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_CRCH;
                end
            end
            S_CRCH: begin
                o_cmd.sel  = SRC_CRCH;
                o_cmd.last = 1'b1;
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_REPORT: begin
                o_cmd.sel  = SRC_REPORT;
                o_cmd.last = 1'b1;
                if (i_status.slot_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.valve_take = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step    <= n_step;
        r_is_read <= n_is_read;
    end

    `MRS_ASSERT_NOW(a_emit_slot_free, i_clk, i_rst_n, o_cmd.emit, i_status.slot_free,
                    "emit into full output register")
    `MRS_ASSERT_NOW(a_check_after_end, i_clk, i_rst_n, r_state == S_CHECK,
                    $past(w_accept && i_req.frame_end), "frame check without frame end")
    `MRS_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, o_cmd.emit && o_cmd.last,
                     r_state == S_IDLE, "no return to idle after last byte")

endmodule

[hdl/modbus_register_slave.sv]
// channel  | modport | transfer carries
// ---------+---------+---------------------------------------------------------
// i_req    | sink    | action, request_byte, frame_end, telemetry_index/value
// o_rsp    | source  | result_kind, response_byte, response_last, valve_command
//
// request items are taken one per cycle while the sequencer is idle
// frame end: a check state, then the header bytes; a read then adds a memory
// fetch state and two data bytes per word; the two crc bytes come last
// a write echoes six frame bytes and the crc; a take yields one valve report
// output stalls hold the sequencer; one result waits in the output register
// synchronous reset clears counters, crc, pending command and word valid bits
module modbus_register_slave #(
    parameter int READ_REG_COUNT    = mrs_pkg::READ_REG_COUNT_DEF,
    parameter int VALVE_REG_ADDRESS = mrs_pkg::VALVE_REG_ADDRESS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    mrs_req_if.sink    i_req,
    mrs_rsp_if.source  o_rsp
);
    import mrs_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    mrs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mrs_datapath #(
        .READ_REG_COUNT    (READ_REG_COUNT),
        .VALVE_REG_ADDRESS (VALVE_REG_ADDRESS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_request_byte    (i_req.request_byte),
        .i_telemetry_index (i_req.telemetry_index),
        .i_telemetry_value (i_req.telemetry_value),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_rsp             (o_rsp)
    );

endmodule

[dv/modbus_register_slave_checker.sv]
module modbus_register_slave_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    mrs_req_if         i_req,
    mrs_rsp_if         i_rsp,
    output int         o_errors,
    output int         o_pending
);
    import mrs_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
        logic [1:0] valve;
    } t_slave_result;

    t_slave_result expected_results[$];

    logic [7:0]  slave_address;
    logic [7:0]  frame_buf[FRAME_LEN];
    logic [3:0]  bytes_seen;
    logic [15:0] frame_crc;
    logic [15:0] holding[READ_REG_COUNT_DEF];
    logic [1:0]  valve_pending;
    logic [7:0]  reply_body[3 + 2 * READ_REG_COUNT_DEF];
    int          errors = 0;

    function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                      input logic [7:0] data);
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    // reply body followed by its crc, low byte first
    task automatic queue_reply(input int len);
        logic [15:0]   crc;
        t_slave_result res;
        crc = CRC_INIT;
        for (int i = 0; i < len + 2; i++) begin
            res.kind  = KIND_BYTE;
            res.valve = VALVE_NONE;
            res.last  = (i == len + 1);
            if (i < len) begin
                res.data = reply_body[i];
                crc = crc16_modbus_step(crc, reply_body[i]);
            end else if (i == len) begin
                res.data = crc[7:0];
            end else begin
                res.data = crc[15:8];
            end
            expected_results.push_back(res);
        end
    endtask

    task automatic predict_slave_reply(input logic [1:0] act, input logic [7:0] rx,
                                       input logic fend, input logic [3:0] idx,
                                       input logic [15:0] val);
        logic [15:0]   start_reg;
        logic [15:0]   reg_count;
        t_slave_result res;
        case (act)
            ACT_BYTE: begin
                if (bytes_seen < COUNT_FULL) begin
                    frame_buf[bytes_seen] = rx;
                    frame_crc = crc16_modbus_step(frame_crc, rx);
                    bytes_seen = bytes_seen + 4'd1;
                end else begin
                    bytes_seen = COUNT_SAT;
                end
                if (fend) begin
                    if (bytes_seen == COUNT_FULL && frame_buf[0] == slave_address &&
                        frame_crc == 16'h0000) begin
                        start_reg = {frame_buf[2], frame_buf[3]};
                        reg_count = {frame_buf[4], frame_buf[5]};
                        if (frame_buf[1] == FN_READ && reg_count != 16'd0 &&
                            int'(start_reg) + int'(reg_count) <= READ_REG_COUNT_DEF) begin
                            reply_body[0] = slave_address;
                            reply_body[1] = FN_READ;
                            reply_body[2] = 8'(reg_count * 2);
                            for (int w = 0; w < int'(reg_count); w++) begin
                                reply_body[3 + 2 * w] = holding[int'(start_reg) + w][15:8];
                                reply_body[4 + 2 * w] = holding[int'(start_reg) + w][7:0];
                            end
                            queue_reply(3 + 2 * int'(reg_count));
                        end else if (frame_buf[1] == FN_WRITE &&
                                     int'(start_reg) == VALVE_REG_ADDRESS_DEF) begin
                            valve_pending = (reg_count == 16'd0) ? VALVE_OPEN : VALVE_CLOSE;
                            reply_body[0] = slave_address;
                            reply_body[1] = FN_WRITE;
                            for (int i = 2; i < 6; i++) begin
                                reply_body[i] = frame_buf[i];
                            end
                            queue_reply(6);
                        end
                    end
                    bytes_seen = 4'd0;
                    frame_crc  = CRC_INIT;
                end
            end
            ACT_TELEM: begin
                if (idx < READ_REG_COUNT_DEF) begin
                    holding[idx] = val;
                end
            end
            ACT_TAKE: begin
                res.kind  = KIND_REPORT;
                res.data  = 8'h00;
                res.last  = 1'b1;
                res.valve = valve_pending;
                expected_results.push_back(res);
                valve_pending = VALVE_NONE;
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_slave_result want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d byte %02h last %0d valve %0d",
                   i_rsp.result_kind, i_rsp.response_byte, i_rsp.response_last,
                   i_rsp.valve_command);
            errors++;
        end else begin
            want = expected_results.pop_front();
            if (i_rsp.result_kind !== want.kind) begin
                $error("result_kind: expected %0d, actual %0d", want.kind, i_rsp.result_kind);
                errors++;
            end
            if (i_rsp.response_byte !== want.data) begin
                $error("response_byte: expected %02h, actual %02h",
                       want.data, i_rsp.response_byte);
                errors++;
            end
            if (i_rsp.response_last !== want.last) begin
                $error("response_last: expected %0d, actual %0d",
                       want.last, i_rsp.response_last);
                errors++;
            end
            if (i_rsp.valve_command !== want.valve) begin
                $error("valve_command: expected %0d, actual %0d",
                       want.valve, i_rsp.valve_command);
                errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slave_address = DEV_ADDR_RESET;
            bytes_seen    = 4'd0;
            frame_crc     = CRC_INIT;
            valve_pending = VALVE_NONE;
            for (int i = 0; i < READ_REG_COUNT_DEF; i++) begin
                holding[i] = 16'h0000;
            end
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                slave_address = i_cfg_wr_data;
            end
            if (i_rsp.valid && i_rsp.ready) begin
                check_result();
            end
            if (i_req.valid && i_req.ready) begin
                predict_slave_reply(i_req.action, i_req.request_byte, i_req.frame_end,
                                    i_req.telemetry_index, i_req.telemetry_value);
            end
        end
        o_pending <= expected_results.size();
        o_errors  <= errors;
    end

endmodule

[dv/modbus_register_slave_tb.sv]
module modbus_register_slave_tb;
    import mrs_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         IDLE_PCT   = 22;
    localparam int         SETTLE     = 40;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;
    int         err_count;
    int         pending_count;

    mrs_req_if req_if ();
    mrs_rsp_if rsp_if ();

    modbus_register_slave dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_if),
        .o_rsp         (rsp_if)
    );

    modbus_register_slave_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_if),
        .i_rsp         (rsp_if),
        .o_errors      (err_count),
        .o_pending     (pending_count)
    );

    int         req_idle_pct = IDLE_PCT;
    int         rsp_idle_pct = IDLE_PCT;
    int         items_sent   = 0;
    int         n_reads      = 0;
    int         n_writes     = 0;
    int         n_broken     = 0;
    int         n_telem      = 0;
    int         n_takes      = 0;
    logic [7:0] cur_address  = DEV_ADDR_RESET;
    logic [7:0] frame_out[12];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    // response side backpressure
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [7:0] rx, input logic fend,
                             input logic [3:0] idx, input logic [15:0] val);
        while ($urandom_range(99) < req_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid           <= 1'b1;
        req_if.action          <= act;
        req_if.request_byte    <= rx;
        req_if.frame_end       <= fend;
        req_if.telemetry_index <= idx;
        req_if.telemetry_value <= val;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        if (act != ACT_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) begin
            send_item(ACT_BYTE, frame_out[i], i == len - 1, 4'($urandom), 16'($urandom));
        end
    endtask

    task automatic build_request(input logic [7:0] addr, input logic [7:0] fn,
                                 input logic [15:0] reg_addr, input logic [15:0] reg_val);
        logic [15:0] crc;
        frame_out[0] = addr;
        frame_out[1] = fn;
        frame_out[2] = reg_addr[15:8];
        frame_out[3] = reg_addr[7:0];
        frame_out[4] = reg_val[15:8];
        frame_out[5] = reg_val[7:0];
        crc = CRC_INIT;
        for (int i = 0; i < 6; i++) begin
            crc = crc_feed(crc, frame_out[i]);
        end
        frame_out[6] = crc[7:0];
        frame_out[7] = crc[15:8];
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_address(input logic [7:0] addr);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= addr;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_address = addr;
    endtask

    task automatic run_random_sequence();
        int          pick;
        int          extra;
        logic [15:0] cnt;
        logic [15:0] start;
        logic [15:0] val;
        logic [7:0]  fn;
        pick = $urandom_range(99);
        if (pick < 42) begin
            cnt   = 16'($urandom_range(1, READ_REG_COUNT_DEF));
            start = 16'($urandom_range(0, READ_REG_COUNT_DEF - cnt));
            build_request(cur_address, FN_READ, start, cnt);
            send_frame(FRAME_LEN);
            n_reads++;
        end else if (pick < 56) begin
            start = ($urandom_range(99) < 85) ? 16'(VALVE_REG_ADDRESS_DEF) : 16'($urandom);
            val   = ($urandom_range(99) < 40) ? 16'h0000 : 16'($urandom);
            build_request(cur_address, FN_WRITE, start, val);
            send_frame(FRAME_LEN);
            n_writes++;
        end else if (pick < 68) begin
            case ($urandom_range(9))
                0:       val = 16'h0000;
                1:       val = 16'hFFFF;
                default: val = 16'($urandom);
            endcase
            send_item(ACT_TELEM, 8'($urandom), 1'($urandom),
                      ($urandom_range(99) < 80) ? 4'($urandom_range(0, READ_REG_COUNT_DEF - 1))
                                                : 4'($urandom_range(READ_REG_COUNT_DEF, 15)),
                      val);
            n_telem++;
        end else if (pick < 78) begin
            send_item(ACT_TAKE, 8'($urandom), 1'($urandom), 4'($urandom), 16'($urandom));
            n_takes++;
        end else if (pick < 95) begin
            n_broken++;
            case ($urandom_range(5))
                0: begin
                    // short or random-content frame
                    for (int i = 0; i < 8; i++) begin
                        frame_out[i] = 8'($urandom);
                    end
                    if ($urandom_range(1)) begin
                        frame_out[0] = cur_address;
                    end
                    send_frame($urandom_range(1, FRAME_LEN));
                end
                1: begin
                    // long frame, bytes past the eighth dropped
                    cnt = 16'($urandom_range(1, READ_REG_COUNT_DEF));
                    build_request(cur_address, FN_READ, 16'd0, cnt);
                    extra = $urandom_range(1, 4);
                    for (int i = 8; i < 12; i++) begin
                        frame_out[i] = 8'($urandom);
                    end
                    send_frame(FRAME_LEN + extra);
                end
                2: begin
                    // crc error
                    build_request(cur_address, $urandom_range(1) ? FN_READ : FN_WRITE,
                                  16'($urandom_range(0, 9)), 16'($urandom_range(0, 9)));
                    extra = $urandom_range(0, FRAME_LEN - 1);
                    frame_out[extra] = frame_out[extra] ^ 8'(1 << $urandom_range(7));
                    send_frame(FRAME_LEN);
                end
                3: begin
                    // another slave address
                    build_request(cur_address ^ 8'($urandom_range(1, 255)),
                                  $urandom_range(1) ? FN_READ : FN_WRITE,
                                  16'($urandom_range(0, 9)), 16'($urandom_range(1, 9)));
                    send_frame(FRAME_LEN);
                end
                4: begin
                    // zero-quantity read or read range out of bounds
                    case ($urandom_range(2))
                        0: begin
                            cnt   = 16'd0;
                            start = 16'($urandom_range(0, READ_REG_COUNT_DEF));
                        end
                        1: begin
                            cnt   = 16'($urandom_range(1, READ_REG_COUNT_DEF));
                            start = 16'($urandom_range(READ_REG_COUNT_DEF + 1 - cnt,
                                                       READ_REG_COUNT_DEF));
                        end
                        default: begin
                            cnt   = 16'($urandom);
                            start = 16'($urandom);
                        end
                    endcase
                    build_request(cur_address, FN_READ, start, cnt);
                    send_frame(FRAME_LEN);
                end
                default: begin
                    // unsupported function code
                    fn = 8'($urandom);
                    while (fn == FN_READ || fn == FN_WRITE) begin
                        fn = 8'($urandom);
                    end
                    build_request(cur_address, fn, 16'($urandom_range(0, 9)),
                                  16'($urandom_range(1, 9)));
                    send_frame(FRAME_LEN);
                end
            endcase
        end else begin
            send_item(ACT_UNUSED, 8'($urandom), 1'($urandom), 4'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        logic [7:0] phase_addr[4];
        int         phase_end;
        phase_addr[0] = 8'h00;
        phase_addr[1] = 8'hFF;
        phase_addr[2] = 8'($urandom);
        phase_addr[3] = DEV_ADDR_RESET;

        i_rst_n                <= 1'b0;
        i_cfg_wr_en            <= 1'b0;
        i_cfg_wr_data          <= 8'h00;
        req_if.valid           <= 1'b0;
        req_if.action          <= ACT_BYTE;
        req_if.request_byte    <= 8'h00;
        req_if.frame_end       <= 1'b0;
        req_if.telemetry_index <= 4'd0;
        req_if.telemetry_value <= 16'h0000;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset address
        send_item(ACT_TELEM, 8'h00, 1'b0, 4'd0, 16'hFFFF);
        send_item(ACT_TELEM, 8'hFF, 1'b1, 4'(READ_REG_COUNT_DEF - 1), 16'h0000);
        send_item(ACT_TELEM, 8'h00, 1'b0, 4'(READ_REG_COUNT_DEF), 16'h1234);
        send_item(ACT_TELEM, 8'h00, 1'b0, 4'd15, 16'hFFFF);
        build_request(cur_address, FN_READ, 16'd0, 16'(READ_REG_COUNT_DEF));
        send_frame(FRAME_LEN);
        build_request(cur_address, FN_WRITE, 16'(VALVE_REG_ADDRESS_DEF), 16'h0000);
        send_frame(FRAME_LEN);
        send_item(ACT_TAKE, 8'h00, 1'b0, 4'd0, 16'h0000);
        send_item(ACT_TAKE, 8'hFF, 1'b1, 4'd15, 16'hFFFF);
        send_item(ACT_UNUSED, 8'hFF, 1'b1, 4'd15, 16'hFFFF);
        send_item(ACT_BYTE, cur_address, 1'b1, 4'd0, 16'h0000);
        n_reads++;
        n_writes++;
        n_broken++;
        n_telem += 4;
        n_takes += 2;
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            write_address(phase_addr[p]);
            req_idle_pct = (p == 2) ? 0 : IDLE_PCT;
            rsp_idle_pct = (p == 2) ? 0 : IDLE_PCT;
            phase_end = items_sent + 104;
            while (items_sent < phase_end) begin
                run_random_sequence();
            end
            wait_idle();
        end

        $display("covered %0d request transfers: %0d read frames, %0d valve writes, %0d bad",
                 items_sent, n_reads, n_writes, n_broken);
        $display("or foreign frames, %0d telemetry writes, %0d valve takes over five addresses",
                 n_telem, n_takes);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
